// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CHECK_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a consequence holds in the same cycle as its trigger.
`define CHECK_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mspp_pkg.sv =====
package mspp_pkg;

    localparam int SPR_W        = 12;   // sprite dimension
    localparam int XY_W         = 12;   // placement / rectangle origin
    localparam int WH_W         = 13;   // rectangle extent, page dimension
    localparam int VER_W        = 8;
    localparam int PGO_W        = 4;    // page index field on the result port
    localparam int PADDING      = 1;
    localparam int RESULT_LIMIT = 16;   // reports per flush
    localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

    localparam logic [WH_W-1:0] PAGE_DIM_MIN = 13'd2;
    localparam logic [WH_W-1:0] PAGE_DIM_MAX = 13'd4096;
    localparam logic [WH_W-1:0] PAGE_DIM_RST = 13'd1024;

    localparam logic [1:0] CFG_PAGE_W = 2'd0;
    localparam logic [1:0] CFG_PAGE_H = 2'd1;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_RESET = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_PLACED    = 3'd0,
        ST_NO_ROOM   = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_ACK       = 3'd3,
        ST_REPORT    = 3'd4
    } t_status;

endpackage

// ===== rtl/multi_page_shelf_packer.sv =====
// Shelf packer that places sprites into up to MAX_PAGES equal pages.
// Input channel (i_in_valid / o_in_ready) takes one item: add a sprite, reset all
// pages or flush the dirty rectangles. Result channel (o_out_valid / i_out_ready)
// gives one result per add or reset and one report per dirty page, up to
// RESULT_LIMIT, on a flush, the final one marked by o_last. Config channel
// (i_cfg_valid / o_cfg_ready) writes the page width (index 0) or height (index 1),
// clamped to 2..4096; write only when idle. Reset, unused codes, oversized sprites
// and empty flushes pass the emit state to the output register. An add tries the
// open pages, one page record read per cycle from the page memory, and opens a
// fresh page when none fits. A flush walks the open pages one per cycle unless the
// receiver stalls. One item is in flight at a time: o_in_ready is high when the
// sequencer is idle, even while the last result still waits in the output register.
// Receiver stall: the output register holds its item; the sequencer waits.
// Reset: page 0 is open with cursor 1,1 and marked wholly dirty at 1024 x 1024,
// version 0, no result pending. Pages rewound by a reset item are tracked by a
// flag per page, so no memory clearing pass is needed.
`include "assert_macros.svh"

module multi_page_shelf_packer
    import mspp_pkg::*;
#(
    parameter int MAX_PAGES  = 16,
    parameter int COORD_BITS = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_operation,
    input  logic [SPR_W-1:0]      i_sprite_width,
    input  logic [SPR_W-1:0]      i_sprite_height,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_status,
    output logic [PGO_W-1:0]      o_page_index,
    output logic [XY_W-1:0]       o_place_x,
    output logic [XY_W-1:0]       o_place_y,
    output logic [WH_W-1:0]       o_rect_width,
    output logic [WH_W-1:0]       o_rect_height,
    output logic [VER_W-1:0]      o_version,
    output logic                  o_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [WH_W-1:0]       i_cfg_data
);

    localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int OW = $clog2(MAX_PAGES + 1);
    localparam int AW = ((COORD_BITS > WH_W) ? COORD_BITS : WH_W) + 2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_NEW   = 5'b00100,
        S_FLUSH = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    // One page record: shelf cursor plus dirty bounding rectangle.
    typedef struct packed {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] sh;
        logic [XY_W-1:0]       rx;
        logic [XY_W-1:0]       ry;
        logic [WH_W-1:0]       rw;
        logic [WH_W-1:0]       rh;
    } t_rec;

    // ---------------- registers ----------------
    t_state                r_state, n_state;
    logic [PW-1:0]         r_page, n_page;
    logic [OW-1:0]         r_pages_open, n_pages_open;
    logic [MAX_PAGES-1:0]  r_dirty, n_dirty;
    logic [MAX_PAGES-1:0]  r_fresh, n_fresh;       // page rewound, memory record stale
    logic [VER_W-1:0]      r_version, n_version;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [WH_W-1:0]       r_page_w, n_page_w;
    logic [WH_W-1:0]       r_page_h, n_page_h;
    logic [WH_W-1:0]       r_snap_w, n_snap_w;     // page size at the last rewind
    logic [WH_W-1:0]       r_snap_h, n_snap_h;
    logic [SPR_W-1:0]      r_spr_w, n_spr_w;
    logic [SPR_W-1:0]      r_spr_h, n_spr_h;

    t_status               r_res_status, n_res_status;
    logic [PW-1:0]         r_res_page, n_res_page;
    logic [XY_W-1:0]       r_res_x, n_res_x;
    logic [XY_W-1:0]       r_res_y, n_res_y;
    logic [WH_W-1:0]       r_res_w, n_res_w;
    logic [WH_W-1:0]       r_res_h, n_res_h;

    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [PW-1:0]         r_out_page, n_out_page;
    logic [XY_W-1:0]       r_out_x, n_out_x;
    logic [XY_W-1:0]       r_out_y, n_out_y;
    logic [WH_W-1:0]       r_out_w, n_out_w;
    logic [WH_W-1:0]       r_out_h, n_out_h;
    logic [VER_W-1:0]      r_out_ver, n_out_ver;
    logic                  r_out_last, n_out_last;

    t_rec                  r_mem [MAX_PAGES];
    t_rec                  r_rd;

    // ---------------- combinational signals ----------------
    logic                  w_in_acc;
    logic                  w_out_free;
    logic                  w_too_large;
    logic [WH_W-1:0]       w_cfg_val;
    logic [MAX_PAGES-1:0]  w_open_mask;
    logic [MAX_PAGES-1:0]  w_above_mask;
    logic                  w_any_dirty;
    logic                  w_later_dirty;
    logic                  w_fl_last;
    logic [OW-1:0]         w_page_inc;
    t_rec                  w_src;
    logic                  w_src_dirty;
    t_rec                  w_new_rec;
    logic                  w_fit;
    logic [XY_W-1:0]       w_px_out;
    logic [XY_W-1:0]       w_py_out;
    logic                  w_mem_we;
    logic [PW+PGO_W-1:0]   w_pg_ext;

    logic [AW-1:0] a_cx, a_cy, a_sh, a_w, a_h, a_pw, a_ph;
    logic [AW-1:0] a_px, a_py, a_lh, a_pr, a_pb;
    logic [AW-1:0] a_rx, a_ry, a_rr, a_rb, a_l, a_t, a_r, a_b;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_too_large = (i_sprite_width == '0) || (i_sprite_height == '0) ||
                         ({1'b0, i_sprite_width} >= r_page_w) ||
                         ({1'b0, i_sprite_height} >= r_page_h);
    assign w_cfg_val   = (i_cfg_data < PAGE_DIM_MIN) ? PAGE_DIM_MIN :
                         (i_cfg_data > PAGE_DIM_MAX) ? PAGE_DIM_MAX : i_cfg_data;
    assign w_page_inc  = OW'(r_page) + OW'(1);

    always_comb begin
        for (int i = 0; i < MAX_PAGES; i++) begin
            w_open_mask[i]  = (i < int'(r_pages_open));
            w_above_mask[i] = (i > int'(r_page));
        end
    end

    assign w_any_dirty   = |(r_dirty & w_open_mask);
    assign w_later_dirty = |(r_dirty & w_open_mask & w_above_mask);
    assign w_fl_last     = !w_later_dirty || (r_count == CNT_W'(RESULT_LIMIT - 1));

    // Page record under evaluation: a freshly opened page, a rewound page or memory.
    always_comb begin
        w_src       = r_rd;
        w_src_dirty = r_dirty[r_page];
        if (r_state == S_NEW) begin
            w_src.cx    = COORD_BITS'(PADDING);
            w_src.cy    = COORD_BITS'(PADDING);
            w_src.sh    = '0;
            w_src.rx    = '0;
            w_src.ry    = '0;
            w_src.rw    = r_page_w;
            w_src.rh    = r_page_h;
            w_src_dirty = 1'b1;
        end else if (r_fresh[r_page]) begin
            w_src.cx = COORD_BITS'(PADDING);
            w_src.cy = COORD_BITS'(PADDING);
            w_src.sh = '0;
            w_src.rx = '0;
            w_src.ry = '0;
            w_src.rw = r_snap_w;
            w_src.rh = r_snap_h;
        end
    end

    // Shelf placement on one page and the updated record.
    always_comb begin
        a_cx = AW'(w_src.cx);
        a_cy = AW'(w_src.cy);
        a_sh = AW'(w_src.sh);
        a_w  = AW'(r_spr_w);
        a_h  = AW'(r_spr_h);
        a_pw = AW'(r_page_w);
        a_ph = AW'(r_page_h);
        // wrap to a new shelf when the row is too short
        if (a_cx + a_w + AW'(PADDING) > a_pw) begin
            a_px = '0;
            a_py = a_cy + a_sh + AW'(PADDING);
            a_lh = '0;
        end else begin
            a_px = a_cx;
            a_py = a_cy;
            a_lh = a_sh;
        end
        a_pr  = a_px + a_w;
        a_pb  = a_py + a_h;
        w_fit = (a_pb <= a_ph);

        a_rx = AW'(w_src.rx);
        a_ry = AW'(w_src.ry);
        a_rr = a_rx + AW'(w_src.rw);
        a_rb = a_ry + AW'(w_src.rh);
        if (w_src_dirty) begin
            a_l = (a_rx < a_px) ? a_rx : a_px;
            a_t = (a_ry < a_py) ? a_ry : a_py;
            a_r = (a_rr > a_pr) ? a_rr : a_pr;
            a_b = (a_rb > a_pb) ? a_rb : a_pb;
        end else begin
            a_l = a_px;
            a_t = a_py;
            a_r = a_pr;
            a_b = a_pb;
        end

        w_new_rec.cx = COORD_BITS'(a_pr + AW'(PADDING));
        w_new_rec.cy = COORD_BITS'(a_py);
        w_new_rec.sh = COORD_BITS'((a_lh < a_h) ? a_h : a_lh);
        w_new_rec.rx = XY_W'(a_l);
        w_new_rec.ry = XY_W'(a_t);
        w_new_rec.rw = WH_W'(a_r - a_l);
        w_new_rec.rh = WH_W'(a_b - a_t);
        w_px_out     = XY_W'(a_px);
        w_py_out     = XY_W'(a_py);
    end

    assign w_mem_we = ((r_state == S_EVAL) || (r_state == S_NEW)) && w_fit;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state      = r_state;
        n_page       = r_page;
        n_pages_open = r_pages_open;
        n_dirty      = r_dirty;
        n_fresh      = r_fresh;
        n_version    = r_version;
        n_count      = r_count;
        n_page_w     = r_page_w;
        n_page_h     = r_page_h;
        n_snap_w     = r_snap_w;
        n_snap_h     = r_snap_h;
        n_spr_w      = r_spr_w;
        n_spr_h      = r_spr_h;
        n_res_status = r_res_status;
        n_res_page   = r_res_page;
        n_res_x      = r_res_x;
        n_res_y      = r_res_y;
        n_res_w      = r_res_w;
        n_res_h      = r_res_h;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_page   = r_out_page;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_w      = r_out_w;
        n_out_h      = r_out_h;
        n_out_ver    = r_out_ver;
        n_out_last   = r_out_last;

        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_PAGE_W) begin
                n_page_w = w_cfg_val;
            end else if (i_cfg_index == CFG_PAGE_H) begin
                n_page_h = w_cfg_val;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_spr_w      = i_sprite_width;
                    n_spr_h      = i_sprite_height;
                    n_page       = '0;
                    n_count      = '0;
                    n_res_status = ST_ACK;
                    n_res_page   = '0;
                    n_res_x      = '0;
                    n_res_y      = '0;
                    n_res_w      = '0;
                    n_res_h      = '0;
                    n_state      = S_EMIT;
                    case (t_op'(i_operation))
                        OP_ADD: begin
                            if (w_too_large) begin
                                n_res_status = ST_TOO_LARGE;
                                n_res_w      = WH_W'(i_sprite_width);
                                n_res_h      = WH_W'(i_sprite_height);
                            end else begin
                                n_state = S_EVAL;
                            end
                        end
                        OP_RESET: begin
                            // rewind every page; open ones become wholly dirty
                            n_snap_w  = r_page_w;
                            n_snap_h  = r_page_h;
                            n_fresh   = '1;
                            n_dirty   = r_dirty | w_open_mask;
                            n_version = r_version + VER_W'(1);
                        end
                        OP_FLUSH: begin
                            if (w_any_dirty) begin
                                n_state = S_FLUSH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EVAL: begin
                if (w_fit) begin
                    n_dirty[r_page] = 1'b1;
                    n_fresh[r_page] = 1'b0;
                    n_res_status    = ST_PLACED;
                    n_res_page      = r_page;
                    n_res_x         = w_px_out;
                    n_res_y         = w_py_out;
                    n_res_w         = WH_W'(r_spr_w);
                    n_res_h         = WH_W'(r_spr_h);
                    n_state         = S_EMIT;
                end else if (w_page_inc < r_pages_open) begin
                    // advance to the next open page; its record is read now
                    n_page = PW'(w_page_inc);
                end else if (r_pages_open < OW'(MAX_PAGES)) begin
                    n_page  = PW'(r_pages_open);
                    n_state = S_NEW;
                end else begin
                    n_res_status = ST_NO_ROOM;
                    n_res_page   = '0;
                    n_res_x      = '0;
                    n_res_y      = '0;
                    n_res_w      = WH_W'(r_spr_w);
                    n_res_h      = WH_W'(r_spr_h);
                    n_state      = S_EMIT;
                end
            end
            S_NEW: begin
                n_res_w = WH_W'(r_spr_w);
                n_res_h = WH_W'(r_spr_h);
                n_state = S_EMIT;
                if (w_fit) begin
                    n_dirty[r_page] = 1'b1;
                    n_fresh[r_page] = 1'b0;
                    n_pages_open    = r_pages_open + OW'(1);
                    n_res_status    = ST_PLACED;
                    n_res_page      = r_page;
                    n_res_x         = w_px_out;
                    n_res_y         = w_py_out;
                end else begin
                    n_res_status = ST_NO_ROOM;
                    n_res_page   = '0;
                    n_res_x      = '0;
                    n_res_y      = '0;
                end
            end
            S_FLUSH: begin
                if (r_dirty[r_page]) begin
                    if (w_out_free) begin
                        n_out_valid     = 1'b1;
                        n_out_status    = ST_REPORT;
                        n_out_page      = r_page;
                        n_out_x         = r_fresh[r_page] ? '0 : r_rd.rx;
                        n_out_y         = r_fresh[r_page] ? '0 : r_rd.ry;
                        n_out_w         = r_fresh[r_page] ? r_snap_w : r_rd.rw;
                        n_out_h         = r_fresh[r_page] ? r_snap_h : r_rd.rh;
                        n_out_ver       = r_version;
                        n_out_last      = w_fl_last;
                        n_dirty[r_page] = 1'b0;
                        n_count         = r_count + CNT_W'(1);
                        if (w_fl_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_page = PW'(w_page_inc);
                        end
                    end
                end else begin
                    // skip a clean page
                    n_page = PW'(w_page_inc);
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_page   = r_res_page;
                    n_out_x      = r_res_x;
                    n_out_y      = r_res_y;
                    n_out_w      = r_res_w;
                    n_out_h      = r_res_h;
                    n_out_ver    = r_version;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_page       <= '0;
            r_pages_open <= OW'(1);
            r_dirty      <= MAX_PAGES'(1);
            r_fresh      <= '1;
            r_version    <= '0;
            r_count      <= '0;
            r_page_w     <= PAGE_DIM_RST;
            r_page_h     <= PAGE_DIM_RST;
            r_snap_w     <= PAGE_DIM_RST;
            r_snap_h     <= PAGE_DIM_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_page       <= n_page;
            r_pages_open <= n_pages_open;
            r_dirty      <= n_dirty;
            r_fresh      <= n_fresh;
            r_version    <= n_version;
            r_count      <= n_count;
            r_page_w     <= n_page_w;
            r_page_h     <= n_page_h;
            r_snap_w     <= n_snap_w;
            r_snap_h     <= n_snap_h;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_spr_w      <= n_spr_w;
        r_spr_h      <= n_spr_h;
        r_res_status <= n_res_status;
        r_res_page   <= n_res_page;
        r_res_x      <= n_res_x;
        r_res_y      <= n_res_y;
        r_res_w      <= n_res_w;
        r_res_h      <= n_res_h;
        r_out_status <= n_out_status;
        r_out_page   <= n_out_page;
        r_out_x      <= n_out_x;
        r_out_y      <= n_out_y;
        r_out_w      <= n_out_w;
        r_out_h      <= n_out_h;
        r_out_ver    <= n_out_ver;
        r_out_last   <= n_out_last;
    end

    // Page memory: read the page the sequencer moves to, write back a placement.
    // A write only happens on the final step of an add, so no read of the same
    // page can follow before the item is done.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_page] <= w_new_rec;
        end
        r_rd <= r_mem[n_page];
    end

    // ---------------- ports ----------------
    assign w_pg_ext      = {{PGO_W{1'b0}}, r_out_page};
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_page_index  = w_pg_ext[PGO_W-1:0];
    assign o_place_x     = r_out_x;
    assign o_place_y     = r_out_y;
    assign o_rect_width  = r_out_w;
    assign o_rect_height = r_out_h;
    assign o_version     = r_out_ver;
    assign o_last        = r_out_last;

    // ---------------- assertions ----------------
    `CHECK_PROP(a_pages_open_range, (r_pages_open != '0) && (r_pages_open <= OW'(MAX_PAGES)), "open page count out of range")
    `CHECK_IMPL(a_flush_page_open, r_state == S_FLUSH, OW'(r_page) < r_pages_open, "flush walked past the open pages")
    `CHECK_IMPL(a_placed_dirty, (r_state == S_EMIT) && (r_res_status == ST_PLACED), r_dirty[r_res_page], "placed page not dirty")
    `CHECK_PROP(a_report_limit, r_count <= CNT_W'(RESULT_LIMIT), "flush report count over limit")

endmodule
